### hdl/tdat_pkg.sv
// Shared types, codes and the entry match function of the time-of-day alarm table.
package tdat_pkg;

  localparam int unsigned MinuteW = 11;

  // Item opcodes carried on the mode field.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Sun filter codes. The reserved code behaves as "any".
  localparam logic [1:0] FILT_ANY  = 2'd0;
  localparam logic [1:0] FILT_UP   = 2'd1;
  localparam logic [1:0] FILT_DOWN = 2'd2;
  localparam logic [1:0] FILT_RSVD = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_MINUTE  = 3'd1,
    KIND_RISE    = 3'd2,
    KIND_SET     = 3'd3,
    KIND_RISE_LT = 3'd4,
    KIND_RISE_GE = 3'd5,
    KIND_SET_LT  = 3'd6,
    KIND_SET_GE  = 3'd7
  } kind_e;

  // One table word: fired mark plus the programmed entry.
  typedef struct packed {
    logic                 mark;
    kind_e                kind;
    logic [1:0]           filter;
    logic [MinuteW-1:0]   minute;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  function automatic logic entry_active(input entry_t e,
                                        input logic [MinuteW-1:0] now,
                                        input logic [MinuteW-1:0] rise,
                                        input logic [MinuteW-1:0] sset,
                                        input logic up);
    logic blocked;
    logic hit;
    blocked = ((e.filter == FILT_UP) && !up) || ((e.filter == FILT_DOWN) && up);
    case (e.kind)
      KIND_MINUTE:  hit = (now == e.minute);
      KIND_RISE:    hit = (now == rise);
      KIND_SET:     hit = (now == sset);
      KIND_RISE_LT: hit = (now == rise) && (now < e.minute);
      KIND_RISE_GE: hit = (now == rise) && (now >= e.minute);
      KIND_SET_LT:  hit = (now == sset) && (now < e.minute);
      KIND_SET_GE:  hit = (now == sset) && (now >= e.minute);
      default:      hit = 1'b0;
    endcase
    return hit && !blocked;
  endfunction

endpackage

### hdl/time_of_day_alarm_table_top.sv
// Top level of the time-of-day alarm table: sequencer, tick registers and result register.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries an item that is either a
// load (mode 1) or a tick (mode 0); one output channel (out_valid_o/out_ready_i)
// returns exactly one result item per input item, in order.
// A load writes one table entry and clears its fired mark; its result carries a zero
// mask and sun_up 0. A load to an index at or above ENTRIES changes nothing.
// A tick walks the table one entry per cycle through the entry memory: the read of
// entry k overlaps the write-back of entry k-1's mark, so the walk is bound by the
// single read port. A tick passes through the scan, drain and finish states and a load
// goes straight to finish; the block returns to idle, ready for the next item, in the
// same cycle as its result is posted in the output register.
// A finished result sits in the output register; while the receiver stalls, the block
// still accepts the next item and works it up to the point of posting its result.
// Reset clears the sequencer, the output valid bit and the table valid bits, so every
// entry reads as kind none with a clear mark; no clearing pass is needed.
module time_of_day_alarm_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [10:0] now_minute_i,
  input  logic [10:0] sunrise_minute_i,
  input  logic [10:0] sunset_minute_i,
  input  logic [3:0]  entry_index_i,
  input  logic [2:0]  entry_kind_i,
  input  logic [1:0]  sun_filter_i,
  input  logic [10:0] limit_minute_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] fired_mask_o,
  output logic        sun_up_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  tdat_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic            pend_q, pend_d;
  logic            mode_q;
  logic [10:0]     now_q, rise_q, set_q;
  logic            up_q;
  logic [15:0]     mask_q, mask_d;
  logic            out_valid_q;
  logic [15:0]     fired_mask_q;
  logic            sun_up_q;
  logic            out_load;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  tdat_pkg::entry_t ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  tdat_pkg::entry_t ram_rdata;

  logic            accept;
  logic            act;
  logic            fire;
  logic [6:0]      wr_ext;
  logic            load_in_range;
  logic [1:0]      filt_norm;

  assign accept        = in_valid_i && in_ready_o;
  assign in_ready_o    = (state_q == tdat_pkg::ST_IDLE);
  assign load_in_range = ({3'b000, entry_index_i} < 7'(ENTRIES));
  assign filt_norm     = (sun_filter_i == tdat_pkg::FILT_RSVD) ? tdat_pkg::FILT_ANY
                                                               : sun_filter_i;

  // Match of the entry whose read data returned this cycle.
  assign act    = tdat_pkg::entry_active(ram_rdata, now_q, rise_q, set_q, up_q);
  assign fire   = pend_q && act && !ram_rdata.mark;
  assign wr_ext = 7'(wr_idx_q);

  tdat_entry_ram #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    wr_idx_d  = wr_idx_q;
    pend_d    = 1'b0;
    mask_d    = mask_q;
    out_load  = 1'b0;
    ram_raddr = cnt_q;
    ram_waddr = wr_idx_q;
    ram_wdata = ram_rdata;
    ram_we    = 1'b0;

    // Write back the mark of the entry read in the previous cycle.
    if (pend_q) begin
      ram_we         = 1'b1;
      ram_wdata.mark = act;
      if (fire && (wr_ext < 7'd16)) begin
        mask_d = mask_q | (16'd1 << wr_ext[3:0]);
      end
    end

    case (state_q)
      tdat_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mask_d = '0;
          if (mode_i == tdat_pkg::MODE_LOAD) begin
            state_d = tdat_pkg::ST_FINISH;
            if (load_in_range) begin
              ram_we           = 1'b1;
              ram_waddr        = IdxW'(entry_index_i);
              ram_wdata.mark   = 1'b0;
              ram_wdata.kind   = tdat_pkg::kind_e'(entry_kind_i);
              ram_wdata.filter = filt_norm;
              ram_wdata.minute = limit_minute_i;
            end
          end else begin
            cnt_d   = '0;
            state_d = tdat_pkg::ST_SCAN;
          end
        end
      end
      tdat_pkg::ST_SCAN: begin
        pend_d   = 1'b1;
        wr_idx_d = cnt_q;
        if (cnt_q == IdxW'(ENTRIES - 1)) begin
          state_d = tdat_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tdat_pkg::ST_DRAIN: begin
        state_d = tdat_pkg::ST_FINISH;
      end
      tdat_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tdat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdat_pkg::ST_IDLE;
      cnt_q       <= '0;
      wr_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wr_idx_q <= wr_idx_d;
      pend_q   <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    if (accept) begin
      mode_q <= mode_i;
      now_q  <= now_minute_i;
      rise_q <= sunrise_minute_i;
      set_q  <= sunset_minute_i;
      up_q   <= (mode_i == tdat_pkg::MODE_TICK) &&
                (now_minute_i >= sunrise_minute_i) && (now_minute_i < sunset_minute_i);
    end
    if (out_load) begin
      fired_mask_q <= mask_q;
      sun_up_q     <= up_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fired_mask_o = fired_mask_q;
  assign sun_up_o     = sun_up_q;

`ifndef SYNTHESIS
  // A pending write-back only exists while the table walk is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == tdat_pkg::ST_SCAN) || (state_q == tdat_pkg::ST_DRAIN))
    else $error("mark write-back outside the table walk");

  // A load never reports fired entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdat_pkg::ST_FINISH) && (mode_q == tdat_pkg::MODE_LOAD) |-> (mask_q == '0))
    else $error("load result carries a nonzero mask");

  // Once the output slot is free, the result is posted and the block goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdat_pkg::ST_FINISH) && (!out_valid_q || out_ready_i)
      |=> out_valid_o && (state_q == tdat_pkg::ST_IDLE))
    else $error("result not posted from finish state");

  // The walk always passes through the drain state before the result is posted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdat_pkg::ST_DRAIN) |=> (state_q == tdat_pkg::ST_FINISH) && !pend_q)
    else $error("drain did not close the table walk");
`endif

endmodule

### hdl/tdat_entry_ram.sv
// Entry table memory with one write port, one registered read port and per-entry valid bits.
module tdat_entry_ram #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IdxW    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  tdat_pkg::entry_t    wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output tdat_pkg::entry_t    rdata_o
);

  tdat_pkg::entry_t mem [ENTRIES];
  tdat_pkg::entry_t rd_word_q;
  logic [ENTRIES-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_word_q <= mem[raddr_i];
  end

  // An entry never written reads as kind none with a clear mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_word_q : '0;

endmodule
